/* sv/pixel_to_ground_plane_backprojection_assert.svh */
// Assertion macros for the ground-plane back-projection block.
// Used by the top level only; the assertions compile out when SYNTH is defined.
`ifndef PIXEL_TO_GROUND_PLANE_BACKPROJECTION_ASSERT_SVH
`define PIXEL_TO_GROUND_PLANE_BACKPROJECTION_ASSERT_SVH

`ifndef SYNTH
`define BPJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpj assertion failed");
`define BPJ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpj assertion failed");
`else
`define BPJ_ASSERT_IMP(lbl, ante, cons)
`define BPJ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* sv/bpj_pkg.sv */
// Shared types and constants of the ground-plane back-projection block.
// No dependencies.
`timescale 1ns / 1ps
package bpj_pkg;

  localparam int NUM_REGS = 6;
  localparam int CIDX_W   = 3;
  localparam int QW       = 51;   // signed width of q = M*(u,v,1)
  localparam int MQW      = 50;   // magnitude width of q
  localparam int NW       = 82;   // |q| * |c_z|
  localparam int QBITS    = 40;   // quotient bits below the saturation limit
  localparam int LOW_W    = 25;   // split point of the wide product
  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  typedef enum logic [CIDX_W-1:0] {
    REG_M00_M01 = 3'd0,
    REG_M02_M10 = 3'd1,
    REG_M11_M12 = 3'd2,
    REG_M20_M21 = 3'd3,
    REG_M22_CX  = 3'd4,
    REG_CY_CZ   = 3'd5
  } bpj_reg_e;

  typedef struct packed {
    logic [15:0] pixel_u;
    logic [15:0] pixel_v;
  } bpj_in_t;

  typedef struct packed {
    logic [30:0] abs_world_x;
    logic [30:0] abs_world_y;
    logic [30:0] abs_world_z;
    logic        no_intersection;
    logic        saturated;
  } bpj_out_t;

  typedef struct packed {
    logic vld;
    logic zero;
  } bpj_ctl_t;

endpackage

/* sv/pixel_to_ground_plane_backprojection.sv */
// Pixel to ground-plane back-projection through a pinhole camera.
// Throughput: one pixel per cycle unless the output stalls; the divider takes one quotient bit per stage.
// The whole pipeline holds while a result beat waits on a stalled output.
// Reset clears all valid bits and the six configuration registers to zero.
// Depends on bpj_pkg, bpj_qform, bpj_prod, bpj_div and the assertion header.
`timescale 1ns / 1ps
`include "pixel_to_ground_plane_backprojection_assert.svh"
module pixel_to_ground_plane_backprojection (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bpj_pkg::bpj_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bpj_pkg::bpj_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [bpj_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [63:0]                  cfg_data_i
);
  import bpj_pkg::*;

  logic [63:0]      cfg_q [NUM_REGS];
  logic [8:0][31:0] coef;
  logic [31:0]      ca [3];
  logic             en;
  logic             qf_vld;
  logic [2:0][QW-1:0]    qf_q;
  bpj_ctl_t              pr_ctl;
  logic [2:0][NW-1:0]    pr_n;
  logic [MQW-1:0]        pr_d;
  logic [2:0]            pr_neg;
  bpj_ctl_t              dv_ctl;
  logic [2:0][QBITS-1:0] dv_quo;
  logic [2:0]            dv_neg;
  logic [2:0]            dv_sat;
  logic [41:0]      w   [3];
  logic [41:0]      mag [3];
  logic [30:0]      fld [3];
  logic [2:0]       clip;
  bpj_out_t         out_d, out_q;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i && (int'(cfg_idx_i) < NUM_REGS)) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    coef[0] = cfg_q[REG_M00_M01][31:0];
    coef[1] = cfg_q[REG_M00_M01][63:32];
    coef[2] = cfg_q[REG_M02_M10][31:0];
    coef[3] = cfg_q[REG_M02_M10][63:32];
    coef[4] = cfg_q[REG_M11_M12][31:0];
    coef[5] = cfg_q[REG_M11_M12][63:32];
    coef[6] = cfg_q[REG_M20_M21][31:0];
    coef[7] = cfg_q[REG_M20_M21][63:32];
    coef[8] = cfg_q[REG_M22_CX][31:0];
    ca[0]   = cfg_q[REG_M22_CX][63:32];
    ca[1]   = cfg_q[REG_CY_CZ][31:0];
    ca[2]   = cfg_q[REG_CY_CZ][63:32];
  end

  // hold every stage while the output beat is stalled
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  bpj_qform u_qform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .pix_i  (in_data_i),
    .coef_i (coef),
    .vld_o  (qf_vld),
    .q_o    (qf_q)
  );

  bpj_prod u_prod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (qf_vld),
    .q_i    (qf_q),
    .cz_i   (ca[2]),
    .ctl_o  (pr_ctl),
    .n_o    (pr_n),
    .d_o    (pr_d),
    .neg_o  (pr_neg)
  );

  bpj_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (pr_ctl),
    .n_i    (pr_n),
    .d_i    (pr_d),
    .neg_i  (pr_neg),
    .ctl_o  (dv_ctl),
    .quo_o  (dv_quo),
    .neg_o  (dv_neg),
    .sat_o  (dv_sat)
  );

  // apply sign, subtract offset, take magnitude and clip; flag no intersection when q_z is zero
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      w[a]    = (dv_neg[a] ? (42'd0 - {2'b00, dv_quo[a]}) : {2'b00, dv_quo[a]})
              - {{10{ca[a][31]}}, ca[a]};
      mag[a]  = w[a][41] ? (42'd0 - w[a]) : w[a];
      clip[a] = dv_sat[a] || (mag[a][41:31] != '0);
      fld[a]  = clip[a] ? MAG_MAX : mag[a][30:0];
    end
    if (dv_ctl.zero) begin
      out_d = '{abs_world_x: '0, abs_world_y: '0, abs_world_z: '0,
                no_intersection: 1'b1, saturated: 1'b0};
    end else begin
      out_d = '{abs_world_x: fld[0], abs_world_y: fld[1], abs_world_z: fld[2],
                no_intersection: 1'b0, saturated: |clip};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= dv_ctl.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BPJ_ASSERT_IMP(a_noint_zero, out_valid_o && out_data_o.no_intersection, out_data_o.abs_world_x == '0 && out_data_o.abs_world_y == '0 && out_data_o.abs_world_z == '0 && !out_data_o.saturated)
  `BPJ_ASSERT_IMP(a_sat_max, out_valid_o && out_data_o.saturated, out_data_o.abs_world_x == MAG_MAX || out_data_o.abs_world_y == MAG_MAX || out_data_o.abs_world_z == MAG_MAX)
  `BPJ_ASSERT_IMP(a_freeze, out_valid_o && out_stall_i, in_stall_o)
  `BPJ_ASSERT_NXT(a_drain, out_valid_o && !out_stall_i && !dv_ctl.vld, !out_valid_o)

endmodule

/* sv/bpj_qform.sv */
// Two stages forming q = M*(u,v,1): products, then the row sums.
// Depends on bpj_pkg.
`timescale 1ns / 1ps
module bpj_qform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  bpj_pkg::bpj_in_t                  pix_i,
  input  logic [8:0][31:0]                  coef_i,
  output logic                              vld_o,
  output logic [2:0][bpj_pkg::QW-1:0]       q_o
);
  import bpj_pkg::*;

  logic              v1_q, v2_q;
  logic signed [48:0] pu_q [3];
  logic signed [48:0] pv_q [3];
  logic [QW-1:0]     q_d [3];
  logic [QW-1:0]     q_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        pu_q[a] <= $signed(coef_i[3*a]) * $signed({1'b0, pix_i.pixel_u});
        pv_q[a] <= $signed(coef_i[3*a+1]) * $signed({1'b0, pix_i.pixel_v});
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      q_d[a] = {{2{pu_q[a][48]}}, pu_q[a]} + {{2{pv_q[a][48]}}, pv_q[a]}
             + {{15{coef_i[3*a+2][31]}}, coef_i[3*a+2], 4'b0000};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) q_q[a] <= q_d[a];
    end
  end

  assign vld_o = v2_q;
  always_comb begin
    for (int a = 0; a < 3; a++) q_o[a] = q_q[a];
  end

endmodule

/* sv/bpj_prod.sv */
// Two stages forming |q_a|*|c_z| from split partial products, plus signs and |q_z|.
// Depends on bpj_pkg.
`timescale 1ns / 1ps
module bpj_prod (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [2:0][bpj_pkg::QW-1:0]       q_i,
  input  logic [31:0]                       cz_i,
  output bpj_pkg::bpj_ctl_t                 ctl_o,
  output logic [2:0][bpj_pkg::NW-1:0]       n_o,
  output logic [bpj_pkg::MQW-1:0]           d_o,
  output logic [2:0]                        neg_o
);
  import bpj_pkg::*;

  localparam int HI_W = MQW - LOW_W;

  bpj_ctl_t          c3_q, c4_q;
  logic [QW-1:0]     qm [3];
  logic [31:0]       czm;
  logic [LOW_W+31:0] lo_q [3];
  logic [HI_W+31:0]  hi_q [3];
  logic [MQW-1:0]    d3_q, d4_q;
  logic [2:0]        ng3_q, ng4_q;
  logic [NW-1:0]     n_q [3];

  always_comb begin
    czm = cz_i[31] ? (32'd0 - cz_i) : cz_i;
    for (int a = 0; a < 3; a++) begin
      qm[a] = q_i[a][QW-1] ? ({QW{1'b0}} - q_i[a]) : q_i[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
      c4_q <= '0;
    end else if (en_i) begin
      c3_q <= '{vld: vld_i, zero: (q_i[2] == '0)};
      c4_q <= c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a]  <= qm[a][LOW_W-1:0] * czm;
        hi_q[a]  <= qm[a][MQW-1:LOW_W] * czm;
        ng3_q[a] <= q_i[a][QW-1] ^ cz_i[31] ^ q_i[2][QW-1];
        // combine the partial products
        n_q[a]   <= {hi_q[a], {LOW_W{1'b0}}} + NW'(lo_q[a]);
      end
      d3_q  <= qm[2][MQW-1:0];
      d4_q  <= d3_q;
      ng4_q <= ng3_q;
    end
  end

  assign ctl_o = c4_q;
  assign d_o   = d4_q;
  assign neg_o = ng4_q;
  always_comb begin
    for (int a = 0; a < 3; a++) n_o[a] = n_q[a];
  end

endmodule

/* sv/bpj_div.sv */
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage after a range check stage. Depends on bpj_pkg.
`timescale 1ns / 1ps
module bpj_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  bpj_pkg::bpj_ctl_t                 ctl_i,
  input  logic [2:0][bpj_pkg::NW-1:0]       n_i,
  input  logic [bpj_pkg::MQW-1:0]           d_i,
  input  logic [2:0]                        neg_i,
  output bpj_pkg::bpj_ctl_t                 ctl_o,
  output logic [2:0][bpj_pkg::QBITS-1:0]    quo_o,
  output logic [2:0]                        neg_o,
  output logic [2:0]                        sat_o
);
  import bpj_pkg::*;

  bpj_ctl_t         ctl_q [QBITS+1];
  logic [MQW-1:0]   d_q   [QBITS+1];
  logic [2:0]       neg_q [QBITS+1];
  logic [2:0]       sat_q [QBITS+1];
  logic [MQW-1:0]   rem_q [QBITS+1][3];
  logic [QBITS-1:0] low_q [QBITS+1][3];
  logic [QBITS-1:0] quo_q [QBITS+1][3];

  // range check: quotient at or above 2^QBITS saturates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl_q[0] <= '0;
    else if (en_i) ctl_q[0] <= ctl_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]   <= d_i;
      neg_q[0] <= neg_i;
      for (int a = 0; a < 3; a++) begin
        sat_q[0][a] <= MQW'(n_i[a][NW-1:QBITS]) >= d_i;
        rem_q[0][a] <= MQW'(n_i[a][NW-1:QBITS]);
        low_q[0][a] <= n_i[a][QBITS-1:0];
        quo_q[0][a] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    logic [MQW:0]   t    [3];
    logic [2:0]     ge;
    logic [MQW:0]   diff [3];

    always_comb begin
      for (int a = 0; a < 3; a++) begin
        t[a]    = {rem_q[k-1][a], low_q[k-1][a][QBITS-1]};
        ge[a]   = t[a] >= {1'b0, d_q[k-1]};
        diff[a] = t[a] - {1'b0, d_q[k-1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ctl_q[k] <= '0;
      else if (en_i) ctl_q[k] <= ctl_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k]   <= d_q[k-1];
        neg_q[k] <= neg_q[k-1];
        sat_q[k] <= sat_q[k-1];
        for (int a = 0; a < 3; a++) begin
          rem_q[k][a] <= ge[a] ? diff[a][MQW-1:0] : t[a][MQW-1:0];
          low_q[k][a] <= {low_q[k-1][a][QBITS-2:0], 1'b0};
          quo_q[k][a] <= {quo_q[k-1][a][QBITS-2:0], ge[a]};
        end
      end
    end
  end

  assign ctl_o = ctl_q[QBITS];
  assign neg_o = neg_q[QBITS];
  assign sat_o = sat_q[QBITS];
  always_comb begin
    for (int a = 0; a < 3; a++) quo_o[a] = quo_q[QBITS][a];
  end

endmodule
